// File: design/slcan_command_decoder_defines.svh
// Assertion macros shared by the SLCAN command decoder.
// Expects signals named clk and arst_n in the including scope.
`ifndef SLCAN_COMMAND_DECODER_DEFINES_SVH
`define SLCAN_COMMAND_DECODER_DEFINES_SVH

`define SLCD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("SLCAN decoder assertion failed (same cycle).");

`define SLCD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("SLCAN decoder assertion failed (next cycle).");

`endif

// File: design/slcd_pkg.sv
// Shared types, character codes and helpers for the SLCAN command decoder.
// No dependencies.
package slcd_pkg;

	localparam int unsigned LINE_MAX = 31;
	localparam int unsigned LEN_W = $clog2(LINE_MAX + 1);
	localparam int unsigned CMP_W = LEN_W + 1;

	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_LF = 8'h0A;
	localparam logic [7:0] CHR_V = 8'h56;
	localparam logic [7:0] CHR_N = 8'h4E;
	localparam logic [7:0] CHR_S = 8'h53;
	localparam logic [7:0] CHR_O = 8'h4F;
	localparam logic [7:0] CHR_C = 8'h43;
	localparam logic [7:0] CHR_F = 8'h46;
	localparam logic [7:0] CHR_T_LO = 8'h74;
	localparam logic [7:0] CHR_T_UP = 8'h54;
	localparam logic [7:0] CHR_R_LO = 8'h72;
	localparam logic [7:0] CHR_R_UP = 8'h52;
	localparam logic [7:0] CHR_0 = 8'h30;

	localparam logic [3:0] DIGITS_STD = 4'd3;
	localparam logic [3:0] DIGITS_EXT = 4'd8;
	localparam logic [3:0] MAX_DLC = 4'd8;
	localparam logic [7:0] MAX_RATE = 8'd8;

	typedef enum logic [3:0] {
		CMD_VERSION  = 4'd0,
		CMD_SERIAL   = 4'd1,
		CMD_BITRATE  = 4'd2,
		CMD_BAD_RATE = 4'd3,
		CMD_OPEN     = 4'd4,
		CMD_CLOSE    = 4'd5,
		CMD_FLAGS    = 4'd6,
		CMD_SEND_STD = 4'd7,
		CMD_SEND_EXT = 4'd8,
		CMD_RTR_STD  = 4'd9,
		CMD_RTR_EXT  = 4'd10
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        valid;
		logic [3:0]  rate_index;
		logic [63:0] frame_data;
		logic [3:0]  frame_length;
		logic [31:0] frame_id;
		cmd_t        command;
	} result_t;

	function automatic logic [3:0] nibble_of(input logic [7:0] b);
		logic [3:0] h;
		h = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h = 4'(b - 8'h37);
		end
		return h;
	endfunction

endpackage

// File: design/slcd_in_reg.sv
// Input register stage of the SLCAN command decoder.
// Depends on slcd_pkg.
module slcd_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,
	input  logic              adv,
	output slcd_pkg::in_item_t in_s1
);
	import slcd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	assign in_s1.valid = valid_s1;
	assign in_s1.rx_byte = byte_s1;

endmodule

// File: design/slcd_parser.sv
// Line state and per-byte decode of the SLCAN command decoder.
// Depends on slcd_pkg.
module slcd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  slcd_pkg::in_item_t in_s1,
	input  logic               adv,
	output slcd_pkg::result_t  res
);
	import slcd_pkg::*;

	logic [7:0]       first_q, first_d;
	logic [7:0]       index_q, index_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [31:0]      id_q, id_d;
	logic [3:0]       dlc_q, dlc_d;
	logic [63:0]      data_q, data_d;
	logic             open_q, open_d;

	logic             fire;
	logic [7:0]       b;
	logic [3:0]       h;
	logic [3:0]       digits;
	logic [CMP_W-1:0] pos;
	logic [CMP_W-1:0] k;
	logic [7:0]       idx;

	always_comb begin
		fire = in_s1.valid && adv;
		b = in_s1.rx_byte;
		h = nibble_of(b);
		first_d = first_q;
		index_d = index_q;
		len_d = len_q;
		id_d = id_q;
		dlc_d = dlc_q;
		data_d = data_q;
		open_d = open_q;
		res = '0;
		unique case (first_q)
			CHR_T_UP: digits = DIGITS_EXT;
			CHR_T_LO: digits = DIGITS_STD;
			default:  digits = 4'd0;
		endcase
		pos = CMP_W'(len_q);
		k = pos - CMP_W'(digits) - CMP_W'(2);
		idx = index_q - CHR_0;

		if (b == CHR_CR || b == CHR_LF) begin
			if (len_q != '0) begin
				len_d = '0;
				unique case (first_q)
					CHR_V: begin
						res.valid = 1'b1;
						res.command = CMD_VERSION;
					end
					CHR_N: begin
						res.valid = 1'b1;
						res.command = CMD_SERIAL;
					end
					CHR_S: begin
						if (len_q >= LEN_W'(2)) begin
							res.valid = 1'b1;
							if (idx <= MAX_RATE) begin
								res.command = CMD_BITRATE;
								res.rate_index = idx[3:0];
								open_d = 1'b0;
							end else begin
								res.command = CMD_BAD_RATE;
							end
						end
					end
					CHR_O: begin
						res.valid = 1'b1;
						res.command = CMD_OPEN;
						open_d = 1'b1;
					end
					CHR_C: begin
						res.valid = 1'b1;
						res.command = CMD_CLOSE;
						open_d = 1'b0;
					end
					CHR_F: begin
						res.valid = 1'b1;
						res.command = CMD_FLAGS;
					end
					CHR_T_LO, CHR_T_UP: begin
						if (open_q && pos >= CMP_W'(digits) + CMP_W'(2)
							&& pos >= CMP_W'(digits) + CMP_W'(2) + CMP_W'({dlc_q, 1'b0})) begin
							res.valid = 1'b1;
							res.command = (first_q == CHR_T_UP) ? CMD_SEND_EXT : CMD_SEND_STD;
							res.frame_id = id_q;
							res.frame_length = dlc_q;
							res.frame_data = data_q;
						end
					end
					CHR_R_LO: begin
						res.valid = 1'b1;
						res.command = CMD_RTR_STD;
					end
					CHR_R_UP: begin
						res.valid = 1'b1;
						res.command = CMD_RTR_EXT;
					end
					default: begin
						res.valid = 1'b0;
					end
				endcase
			end
		end else if (len_q < LEN_W'(LINE_MAX)) begin
			len_d = len_q + LEN_W'(1);
			if (len_q == '0) begin
				first_d = b;
				index_d = 8'd0;
				id_d = 32'd0;
				dlc_d = 4'd0;
				data_d = 64'd0;
			end else begin
				if (len_q == LEN_W'(1)) begin
					index_d = b;
				end
				if (digits != 4'd0) begin
					if (pos <= CMP_W'(digits)) begin
						id_d = {id_q[27:0], h};
					end else if (pos == CMP_W'(digits) + CMP_W'(1)) begin
						dlc_d = (h > MAX_DLC) ? MAX_DLC : h;
					end else if (k < CMP_W'(16) && {1'b0, k[3:1]} < dlc_q) begin
						for (int j = 0; j < 16; j++) begin
							if (4'(j) == (k[3:0] ^ 4'h1)) begin
								data_d[4*j +: 4] = data_q[4*j +: 4] | h;
							end
						end
					end
				end
			end
		end else begin
			len_d = '0;
		end

		res.valid = res.valid && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 8'd0;
			index_q <= 8'd0;
			len_q <= '0;
			id_q <= 32'd0;
			dlc_q <= 4'd0;
			data_q <= 64'd0;
			open_q <= 1'b1;
		end else if (fire) begin
			first_q <= first_d;
			index_q <= index_d;
			len_q <= len_d;
			id_q <= id_d;
			dlc_q <= dlc_d;
			data_q <= data_d;
			open_q <= open_d;
		end
	end

endmodule

// File: design/slcd_out_reg.sv
// Result register of the SLCAN command decoder, driving the output stream.
// Depends on slcd_pkg.
module slcd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  slcd_pkg::result_t res,
	output logic              adv,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [111:0]      m_axis_tdata
);
	import slcd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign adv = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {4'd0, res_q.rate_index, res_q.frame_data, res_q.frame_length,
		res_q.frame_id, res_q.command};

endmodule

// File: design/slcan_command_decoder.sv
// Top level of the SLCAN command decoder: decodes host ASCII lines into commands.
// A terminator's result goes via the input register and the result register.
// Throughput: one byte per cycle unless the output stalls; one decode per byte.
// The input stays ready while a result waits, as long as one stage is free.
// Reset clears the line state to empty and leaves the bus open; no result is pending.
// Depends on slcd_pkg, slcd_in_reg, slcd_parser, slcd_out_reg and the defines header.
`include "slcan_command_decoder_defines.svh"

module slcan_command_decoder (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata    // [3:0] command, [35:4] frame_id,
	                                     // [39:36] frame_length, [103:40] frame_data,
	                                     // [107:104] rate_index, [111:108] zero
);
	import slcd_pkg::*;

	in_item_t in_s1;
	result_t  res;
	logic     adv;

	slcd_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.adv           (adv),
		.in_s1         (in_s1)
	);

	slcd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.in_s1  (in_s1),
		.adv    (adv),
		.res    (res)
	);

	slcd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	`SLCD_ASSERT_IMP(a_rate_only_bitrate, m_axis_tvalid && m_axis_tdata[3:0] != CMD_BITRATE, m_axis_tdata[107:104] == 4'd0)
	`SLCD_ASSERT_IMP(a_dlc_clamped, m_axis_tvalid, m_axis_tdata[39:36] <= MAX_DLC)
	`SLCD_ASSERT_IMP(a_cmd_range, m_axis_tvalid, m_axis_tdata[3:0] <= CMD_RTR_EXT)
	`SLCD_ASSERT_NXT(a_result_from_item, !in_s1.valid && !m_axis_tvalid, !m_axis_tvalid)

endmodule
